@@ sv/abd_pkg.sv @@
// Shared types and constants for the anchor box decoder with class argmax.
package abd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned COORD_W   = 16;  // Q12.4 pixel values
  localparam int unsigned SCORE_W   = 16;  // Q0.16 scores and thresholds
  localparam int unsigned CLASS_W   = 4;   // class index on the result
  localparam int unsigned NET_W     = 12;  // net size in whole pixels
  localparam int unsigned NCLS_W    = 5;   // num_classes register
  localparam int unsigned WORD_W    = 64;  // four packed scores
  localparam int unsigned PER_WORD  = 4;   // scores per packed word
  localparam int unsigned NUM_WORDS = 4;   // packed score words per item
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned Q5_W      = 17;  // Q12.5 corner and span width

  // Smallest accepted span: one pixel in Q12.5
  localparam logic [Q5_W-1:0] MIN_SPAN = 17'd32;

  // Reset values of the configuration registers
  localparam logic [NET_W-1:0]  NET_W_RST  = 12'd640;
  localparam logic [NET_W-1:0]  NET_H_RST  = 12'd640;
  localparam logic [NCLS_W-1:0] NUM_CLS_RST = 5'd16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NET_WIDTH     = 3'd0,
    REG_NET_HEIGHT    = 3'd1,
    REG_NUM_CLASSES   = 3'd2,
    REG_THR_0_3       = 3'd3,
    REG_THR_4_7       = 3'd4,
    REG_THR_8_11      = 3'd5,
    REG_THR_12_15     = 3'd6
  } cfg_reg_t;

  // Best score found by one lane
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } lane_res_t;

  // Clamped corner and span of one axis, Q12.5
  typedef struct packed {
    logic [Q5_W-1:0] lo;
    logic [Q5_W-1:0] span;
  } axis_res_t;

  // One result item
  typedef struct packed {
    logic               keep;
    logic [CLASS_W-1:0] cls_idx;
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic               frame_end;
  } out_item_t;

endpackage

@@ sv/abd_in_if.sv @@
// Anchor input channel: valid/ready handshake with the anchor payload.
interface abd_in_if
  import abd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COORD_W-1:0] box_w;
  logic [COORD_W-1:0] box_h;
  logic [WORD_W-1:0]  scores_0_3;
  logic [WORD_W-1:0]  scores_4_7;
  logic [WORD_W-1:0]  scores_8_11;
  logic [WORD_W-1:0]  scores_12_15;
  logic               last_anchor;

  modport source (
    output valid, center_x, center_y, box_w, box_h,
    output scores_0_3, scores_4_7, scores_8_11, scores_12_15, last_anchor,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, box_w, box_h,
    input  scores_0_3, scores_4_7, scores_8_11, scores_12_15, last_anchor,
    output ready
  );
endinterface

@@ sv/abd_out_if.sv @@
// Detection result channel: valid/ready handshake with the result payload.
interface abd_out_if
  import abd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               keep;
  logic [CLASS_W-1:0] cls_idx;
  logic [SCORE_W-1:0] confidence;
  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [COORD_W-1:0] width;
  logic [COORD_W-1:0] height;
  logic               frame_end;

  modport source (
    output valid, keep, cls_idx, confidence, left, top, width, height, frame_end,
    input  ready
  );

  modport sink (
    input  valid, keep, cls_idx, confidence, left, top, width, height, frame_end,
    output ready
  );
endinterface

@@ sv/abd_lane.sv @@
// One argmax lane: best of four packed class scores, registered.
module abd_lane
  import abd_pkg::*;
#(
  parameter int unsigned BASE = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] scores,
  input  logic [NCLS_W-1:0] num_cls,
  output lane_res_t         res
);

  lane_res_t res_r;
  lane_res_t res_nxt;

  // Scan the four scores, strict greater keeps the lower class on a tie
  always_comb begin
    res_nxt.score = '0;
    res_nxt.cls   = CLASS_W'(BASE);
    for (int k = 0; k < PER_WORD; k++) begin
      if ((NCLS_W'(BASE + k) < num_cls) &&
          (scores[k*SCORE_W +: SCORE_W] > res_nxt.score)) begin
        res_nxt.score = scores[k*SCORE_W +: SCORE_W];
        res_nxt.cls   = CLASS_W'(BASE + k);
      end
    end
  end

  // Hold while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ sv/abd_axis.sv @@
// One box axis: centre and size to clamped Q12.5 corner and span, registered.
module abd_axis
  import abd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] center,
  input  logic [COORD_W-1:0] size,
  input  logic [NET_W-1:0]   bound,
  output axis_res_t          res
);

  localparam int unsigned SW = Q5_W + 2;

  logic signed [SW-1:0] lim;
  logic signed [SW-1:0] lo_raw;
  logic signed [SW-1:0] hi_raw;
  logic signed [SW-1:0] lo_cl;
  logic signed [SW-1:0] hi_cl;
  axis_res_t            res_r;
  axis_res_t            res_nxt;

  // Corners in Q12.5: 2*c - s and 2*c + s
  assign lim    = $signed({2'b00, bound, 5'b00000});
  assign lo_raw = $signed({2'b00, center, 1'b0}) - $signed({3'b000, size});
  assign hi_raw = $signed({2'b00, center, 1'b0}) + $signed({3'b000, size});

  // Clamp each corner to [0, bound*32]
  always_comb begin
    lo_cl = lo_raw;
    if (lo_raw < 0) begin
      lo_cl = '0;
    end else if (lo_raw > lim) begin
      lo_cl = lim;
    end
    hi_cl = hi_raw;
    if (hi_raw < 0) begin
      hi_cl = '0;
    end else if (hi_raw > lim) begin
      hi_cl = lim;
    end
    res_nxt.lo   = lo_cl[Q5_W-1:0];
    res_nxt.span = hi_cl[Q5_W-1:0] - lo_cl[Q5_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ sv/abd_merge.sv @@
// Merge stage: combine lane winners, apply class threshold and size check.
module abd_merge
  import abd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 16,
  parameter int unsigned NUM_LANES   = 4,
  parameter int unsigned CLS_IW      = 4
) (
  input  lane_res_t          lane_res [NUM_LANES],
  input  logic [SCORE_W-1:0] thr      [MAX_CLASSES],
  input  axis_res_t          x_res,
  input  axis_res_t          y_res,
  input  logic               frame_end,
  output out_item_t          item
);

  lane_res_t          best;
  logic [SCORE_W-1:0] best_thr;
  logic               keep;

  // Lanes in class order, strict greater from score 0 at class 0
  always_comb begin
    best.score = '0;
    best.cls   = '0;
    for (int g = 0; g < NUM_LANES; g++) begin
      if (lane_res[g].score > best.score) begin
        best = lane_res[g];
      end
    end
  end

  assign best_thr = thr[best.cls[CLS_IW-1:0]];

  assign keep = (best.score >= best_thr) &&
                (x_res.span >= MIN_SPAN) && (y_res.span >= MIN_SPAN);

  // Zero everything but the frame mark on a rejected anchor
  always_comb begin
    item           = '0;
    item.frame_end = frame_end;
    if (keep) begin
      item.keep       = 1'b1;
      item.cls_idx    = best.cls;
      item.confidence = best.score;
      item.left       = x_res.lo[Q5_W-1:1];
      item.top        = y_res.lo[Q5_W-1:1];
      item.width      = x_res.span[Q5_W-1:1];
      item.height     = y_res.span[Q5_W-1:1];
    end
  end

endmodule

@@ sv/anchor_box_decode_argmax.sv @@
// Top level: anchor box decoder with class argmax over parallel score lanes.
// Path: each anchor is registered in the lane and axis units, then merged into the output register.
// Throughput: one anchor per cycle unless stalled; each score lane and axis unit takes a new item every cycle.
// Stalls: the pipeline holds when the output item is not taken; empty stages still fill.
// Reset: rst_n is synchronous, active low; it empties the pipeline and loads
// net size 640x640, all classes enabled and zero thresholds.
module anchor_box_decode_argmax
  import abd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 16  // 4 to 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  abd_in_if.sink               in_ch,
  abd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned NUM_LANES = (MAX_CLASSES + PER_WORD - 1) / PER_WORD;
  localparam int unsigned CLS_IW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic [NET_W-1:0]   net_w_r;
  logic [NET_W-1:0]   net_h_r;
  logic [NCLS_W-1:0]  num_cls_r;
  logic [SCORE_W-1:0] thr_r [MAX_CLASSES];
  logic [NCLS_W-1:0]  num_cls_eff;

  logic               s1_valid_r;
  logic               s1_last_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  out_item_t          merge_item;
  logic               en_out;
  logic               en_s1;

  logic [WORD_W-1:0]  score_w  [NUM_WORDS];
  lane_res_t          lane_res [NUM_LANES];
  axis_res_t          x_res;
  axis_res_t          y_res;

  // Scalar configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_w_r   <= NET_W_RST;
      net_h_r   <= NET_H_RST;
      num_cls_r <= NUM_CLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NET_WIDTH:   net_w_r   <= cfg_data[NET_W-1:0];
        REG_NET_HEIGHT:  net_h_r   <= cfg_data[NET_W-1:0];
        REG_NUM_CLASSES: num_cls_r <= cfg_data[NCLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-class thresholds, four to a register
  for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_thr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        thr_r[c] <= '0;
      end else if (cfg_we &&
                   (cfg_index == CFG_IDX_W'(int'(REG_THR_0_3) + (c >> 2)))) begin
        thr_r[c] <= cfg_data[(c & 3) * SCORE_W +: SCORE_W];
      end
    end
  end

  // Saturate the class count to the lanes built
  assign num_cls_eff = (num_cls_r > NCLS_W'(MAX_CLASSES)) ? NCLS_W'(MAX_CLASSES)
                                                          : num_cls_r;

  // Advance a stage when the one after it is empty or moving
  assign en_out      = !out_valid_r || out_ch.ready;
  assign en_s1       = !s1_valid_r || en_out;
  assign in_ch.ready = en_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (en_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_last_r <= in_ch.last_anchor;
    end
    if (en_out) begin
      out_item_r <= merge_item;
    end
  end

  assign score_w[0] = in_ch.scores_0_3;
  assign score_w[1] = in_ch.scores_4_7;
  assign score_w[2] = in_ch.scores_8_11;
  assign score_w[3] = in_ch.scores_12_15;

  // Score lanes, one per packed word
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    abd_lane #(
      .BASE (g * PER_WORD)
    ) u_lane (
      .clk     (clk),
      .en      (en_s1),
      .scores  (score_w[g]),
      .num_cls (num_cls_eff),
      .res     (lane_res[g])
    );
  end

  abd_axis u_axis_x (
    .clk    (clk),
    .en     (en_s1),
    .center (in_ch.center_x),
    .size   (in_ch.box_w),
    .bound  (net_w_r),
    .res    (x_res)
  );

  abd_axis u_axis_y (
    .clk    (clk),
    .en     (en_s1),
    .center (in_ch.center_y),
    .size   (in_ch.box_h),
    .bound  (net_h_r),
    .res    (y_res)
  );

  abd_merge #(
    .MAX_CLASSES (MAX_CLASSES),
    .NUM_LANES   (NUM_LANES),
    .CLS_IW      (CLS_IW)
  ) u_merge (
    .lane_res  (lane_res),
    .thr       (thr_r),
    .x_res     (x_res),
    .y_res     (y_res),
    .frame_end (s1_last_r),
    .item      (merge_item)
  );

  // Drive the result channel from the output register
  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = out_item_r.keep;
  assign out_ch.cls_idx    = out_item_r.cls_idx;
  assign out_ch.confidence = out_item_r.confidence;
  assign out_ch.left       = out_item_r.left;
  assign out_ch.top        = out_item_r.top;
  assign out_ch.width      = out_item_r.width;
  assign out_ch.height     = out_item_r.height;
  assign out_ch.frame_end  = out_item_r.frame_end;

`ifndef NO_ASSERTIONS
  // An accepted item always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted item lost before first stage");

  // A stalled first stage keeps its item
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !en_out) |=> s1_valid_r)
    else $error("first stage dropped an item under stall");

  // A kept box is at least one pixel on each side
  a_keep_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.keep) |->
      (out_item_r.width >= 16'd16 && out_item_r.height >= 16'd16))
    else $error("kept box smaller than one pixel");

  // A rejected anchor carries zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.keep) |->
      (out_item_r.cls_idx == '0 && out_item_r.confidence == '0 &&
       out_item_r.left == '0 && out_item_r.top == '0 &&
       out_item_r.width == '0 && out_item_r.height == '0))
    else $error("rejected anchor with nonzero fields");

  // A winning class lies among the configured classes
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.keep && out_item_r.confidence != '0) |->
      ({1'b0, out_item_r.cls_idx} < num_cls_eff))
    else $error("winning class outside configured range");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the anchor box decoder with class argmax.
`timescale 1ns / 1ps

module tb
  import abd_pkg::*;
;

  // Class count built into the block under test
  localparam int CLASS_LANES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int DIR_ROWS = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  // One anchor as the sender sees it; lane k of score is class k
  typedef struct packed {
    logic [COORD_W-1:0]                  cx;
    logic [COORD_W-1:0]                  cy;
    logic [COORD_W-1:0]                  bw;
    logic [COORD_W-1:0]                  bh;
    logic [CLASS_LANES-1:0][SCORE_W-1:0] score;
    logic                                last;
  } anchor_t;

  // Register settings held by the predictor
  typedef struct packed {
    logic [NET_W-1:0]                    net_w;
    logic [NET_W-1:0]                    net_h;
    logic [NCLS_W-1:0]                   num_cls;
    logic [CLASS_LANES-1:0][SCORE_W-1:0] thr;
  } cfg_set_t;

  // Directed row: register preset, anchor, and a typed result where obvious
  typedef struct packed {
    logic [2:0] preset;
    anchor_t    stim;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  localparam out_item_t REJECT_ITEM = '0;
  localparam out_item_t REJECT_LAST = '{1'b0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};

  localparam cfg_set_t PRESETS [5] = '{
    '{12'd640, 12'd640, 5'd16, 256'h0},
    '{12'd640, 12'd640, 5'd0, 256'h0},
    '{12'd4095, 12'd4095, 5'd31, {4{64'h8000_8000_8000_8000}}},
    '{12'd0, 12'd1, 5'd1, 256'h0},
    '{12'd4095, 12'd4095, 5'd4, {{3{64'hFFFF_FFFF_FFFF_FFFF}}, 64'h0400_0300_0200_0100}}
  };

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // reset settings: empty box, centered box, everything at maximum
    '{3'd0, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 256'h0, 1'b0}, 1'b1, REJECT_ITEM},
    '{3'd0, '{16'h1400, 16'h1400, 16'h0640, 16'h0640, 256'h0, 1'b1}, 1'b1,
      '{1'b1, 4'd0, 16'h0000, 16'h10E0, 16'h10E0, 16'h0640, 16'h0640, 1'b1}},
    '{3'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, {256{1'b1}}, 1'b1}, 1'b1, REJECT_LAST},
    '{3'd0, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'hFFFF_0000_0000_0000, 64'h0, 64'h0, 64'h0}, 1'b0}, 1'b0, REJECT_ITEM},
    // tie between two lanes keeps the lower class
    '{3'd0, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0000_0000_1234_0000, 64'h0000_0000_1234_0000, 64'h0011_0022_0033_0044},
      1'b0}, 1'b0, REJECT_ITEM},
    '{3'd0, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0010_000F_000E_000D, 64'h000C_000B_000A_0009,
       64'h0008_0007_0006_0005, 64'h0004_0003_0002_0001}, 1'b0}, 1'b0, REJECT_ITEM},
    // clamp at left/top, then at right/bottom
    '{3'd0, '{16'h0010, 16'h0010, 16'h0640, 16'h0640, {4{64'h0101_0202_0303_0404}}, 1'b0},
      1'b0, REJECT_ITEM},
    '{3'd0, '{16'h27F0, 16'h27F0, 16'h0320, 16'h0320,
      {64'h0, 64'h0000_0000_0000_9000, 64'h0, 64'h0}, 1'b1}, 1'b0, REJECT_ITEM},
    // exactly one pixel survives, just under one pixel does not
    '{3'd0, '{16'h1400, 16'h1400, 16'h0010, 16'h0010, 256'h0, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd0, '{16'h1400, 16'h1400, 16'h000F, 16'h0100, 256'h0, 1'b0}, 1'b1, REJECT_ITEM},
    '{3'd0, '{16'h1401, 16'h1403, 16'h0011, 16'h0013,
      {64'h0, 64'h0, 64'h0000_4321_0000_0000, 64'h0000_0000_1111_0000}, 1'b0},
      1'b0, REJECT_ITEM},
    '{3'd0, '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b1},
      1'b0, REJECT_ITEM},
    '{3'd0, '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, {4{64'h5555_5555_5555_5555}}, 1'b0},
      1'b0, REJECT_ITEM},
    // no lane competes: class 0 with score 0
    '{3'd1, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'h0, 64'hFFFF_0000_0000_0000}, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd1, '{16'h1400, 16'h1400, 16'h0640, 16'h0640, 256'h0, 1'b1}, 1'b0, REJECT_ITEM},
    // class count saturates, largest net, thresholds at one half
    '{3'd2, '{16'hFF00, 16'hFF00, 16'h0200, 16'h0200,
      {64'hFFFF_0000_0000_0000, 64'h0, 64'h0, 64'h0}, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd2, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_7FFF}, 1'b0}, 1'b1, REJECT_ITEM},
    '{3'd2, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'h8000_0000_0000_0000, 64'h0}, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd2, '{16'h7FF8, 16'h7FF8, 16'hFFF0, 16'hFFF0,
      {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_C000}, 1'b1}, 1'b0, REJECT_ITEM},
    // zero net width rejects every box
    '{3'd3, '{16'h1400, 16'h1400, 16'h0640, 16'h0640, 256'h0, 1'b1}, 1'b1, REJECT_LAST},
    '{3'd3, '{16'h0000, 16'h0000, 16'h0100, 16'h0100,
      {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_FFFF}, 1'b0}, 1'b0, REJECT_ITEM},
    // per-class thresholds: scores under their threshold fail, lanes past the count ignored
    '{3'd4, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'h0, 64'h0000_0200_0000_0000}, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd4, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'h0, 64'h0000_01FF_0000_0000}, 1'b0}, 1'b0, REJECT_ITEM},
    '{3'd4, '{16'h1400, 16'h1400, 16'h0640, 16'h0640,
      {64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0050_0000_0000_0000}, 1'b1},
      1'b0, REJECT_ITEM}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  abd_in_if  in_ch ();
  abd_out_if out_ch ();

  out_item_t expected_dets[$];
  cfg_set_t  cur_cfg = PRESETS[0];
  int        mismatch_count = 0;
  int        sent_count = 0;
  int        cycle_count = 0;

  anchor_box_decode_argmax #(.MAX_CLASSES(CLASS_LANES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp both corners of one axis to [0, lim] in Q12.5
  function automatic void clamp_axis(input int c, input int s, input int lim,
                                     output int lo, output int hi);
    lo = 2 * c - s;
    hi = 2 * c + s;
    if (lo < 0) lo = 0;
    if (lo > lim) lo = lim;
    if (hi < 0) hi = 0;
    if (hi > lim) hi = lim;
  endfunction

  // Work out the detection for one anchor under the current settings
  function automatic out_item_t predict_detection(input anchor_t a);
    logic [SCORE_W-1:0] best;
    logic [CLASS_W-1:0] best_cls;
    int                 lanes;
    int                 k;
    int                 x1, x2, y1, y2;
    logic               keep;
    out_item_t          det;
    lanes = (cur_cfg.num_cls > CLASS_LANES) ? CLASS_LANES : int'(cur_cfg.num_cls);
    best = '0;
    best_cls = '0;
    for (k = 0; k < lanes; k++) begin
      if (a.score[k] > best) begin
        best = a.score[k];
        best_cls = CLASS_W'(k);
      end
    end
    keep = !(best < cur_cfg.thr[best_cls]);
    clamp_axis(int'(a.cx), int'(a.bw), int'(cur_cfg.net_w) * 32, x1, x2);
    clamp_axis(int'(a.cy), int'(a.bh), int'(cur_cfg.net_h) * 32, y1, y2);
    if (x2 - x1 < int'(MIN_SPAN) || y2 - y1 < int'(MIN_SPAN)) keep = 1'b0;
    det = '0;
    if (keep) begin
      det.keep = 1'b1;
      det.cls_idx = best_cls;
      det.confidence = best;
      det.left = COORD_W'(x1 >> 1);
      det.top = COORD_W'(y1 >> 1);
      det.width = COORD_W'((x2 - x1) >> 1);
      det.height = COORD_W'((y2 - y1) >> 1);
    end
    det.frame_end = a.last;
    return det;
  endfunction

  function automatic logic [NET_W-1:0] pick_net();
    case ($urandom_range(0, 5))
      0: return 12'd4095;
      1: return 12'd1;
      2: return 12'd640;
      5: return ($urandom_range(0, 3) == 0) ? 12'd0 : 12'd320;
      default: return NET_W'($urandom_range(1, 4095));
    endcase
  endfunction

  // Settings for one random phase; the first two sit at the extremes
  function automatic cfg_set_t rand_config(input int phase);
    cfg_set_t c;
    int       k;
    if (phase == 0) return '{12'd4095, 12'd4095, 5'd16, 256'h0};
    if (phase == 1) return '{12'd1, 12'd1, 5'd1, {256{1'b1}}};
    c.net_w = pick_net();
    c.net_h = pick_net();
    case ($urandom_range(0, 7))
      0: c.num_cls = 5'd0;
      1: c.num_cls = NCLS_W'($urandom_range(17, 31));
      default: c.num_cls = NCLS_W'($urandom_range(1, 16));
    endcase
    for (k = 0; k < CLASS_LANES; k++) begin
      case ($urandom_range(0, 3))
        0: c.thr[k] = '0;
        1: c.thr[k] = SCORE_W'($urandom_range(0, 65535));
        2: c.thr[k] = 16'hFFFF;
        default: c.thr[k] = SCORE_W'($urandom_range(0, 16'h4000));
      endcase
    end
    return c;
  endfunction

  // Mostly boxes that fit the net, the rest raw noise
  function automatic anchor_t rand_anchor();
    anchor_t     a;
    int unsigned span_x, span_y;
    int          k;
    if ($urandom_range(0, 9) < 7) begin
      span_x = cur_cfg.net_w * 16;
      span_y = cur_cfg.net_h * 16;
      a.cx = COORD_W'($urandom_range(0, span_x));
      a.cy = COORD_W'($urandom_range(0, span_y));
      a.bw = COORD_W'($urandom_range(0, (span_x > 0) ? span_x : 64));
      a.bh = COORD_W'($urandom_range(0, (span_y > 0) ? span_y : 64));
      if ($urandom_range(0, 3) == 0) a.bw = COORD_W'($urandom_range(0, 48));
      if ($urandom_range(0, 3) == 0) a.bh = COORD_W'($urandom_range(0, 48));
    end else begin
      a.cx = COORD_W'($urandom());
      a.cy = COORD_W'($urandom());
      a.bw = COORD_W'($urandom());
      a.bh = COORD_W'($urandom());
    end
    for (k = 0; k < CLASS_LANES; k++) begin
      case ($urandom_range(0, 4))
        2: a.score[k] = SCORE_W'($urandom_range(0, 511));
        3: a.score[k] = (k > 0) ? a.score[k-1] : 16'hFFFF;
        4: a.score[k] = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        default: a.score[k] = SCORE_W'($urandom_range(0, 65535));
      endcase
    end
    a.last = ($urandom_range(0, 15) == 0);
    return a;
  endfunction

  // Offer one anchor and hold it until taken; record what it must produce
  task automatic send_anchor(input anchor_t a, input logic typed, input out_item_t typed_det);
    in_ch.valid <= 1'b1;
    in_ch.center_x <= a.cx;
    in_ch.center_y <= a.cy;
    in_ch.box_w <= a.bw;
    in_ch.box_h <= a.bh;
    in_ch.scores_0_3 <= a.score[3:0];
    in_ch.scores_4_7 <= a.score[7:4];
    in_ch.scores_8_11 <= a.score[11:8];
    in_ch.scores_12_15 <= a.score[15:12];
    in_ch.last_anchor <= a.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_dets.insert(expected_dets.size(), typed ? typed_det : predict_detection(a));
    sent_count++;
  endtask

  task automatic idle_gap(input int n);
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every pending detection to come out
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_dets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Write every register, with noise above the used bits, plus an unused index
  task automatic apply_config(input cfg_set_t c);
    logic [CFG_DAT_W-1:0] noise;
    noise = {$urandom(), $urandom()};
    put_reg(REG_NET_WIDTH, {noise[63:12], c.net_w});
    put_reg(REG_NET_HEIGHT, {noise[51:0], c.net_h});
    put_reg(REG_NUM_CLASSES, {noise[63:5], c.num_cls});
    put_reg(REG_THR_0_3, c.thr[3:0]);
    put_reg(REG_THR_4_7, c.thr[7:4]);
    put_reg(REG_THR_8_11, c.thr[11:8]);
    put_reg(REG_THR_12_15, c.thr[15:12]);
    put_reg(CFG_IDX_UNUSED, noise);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each detection taken with the oldest one pending
  always @(posedge clk) begin : det_monitor
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_dets.size() == 0) begin
        $error("detection with no anchor pending");
        mismatch_count++;
      end else begin
        want = expected_dets.pop_front();
        check_field("keep", 16'(want.keep), 16'(out_ch.keep));
        check_field("cls_idx", 16'(want.cls_idx), 16'(out_ch.cls_idx));
        check_field("confidence", want.confidence, out_ch.confidence);
        check_field("left", want.left, out_ch.left);
        check_field("top", want.top, out_ch.top);
        check_field("width", want.width, out_ch.width);
        check_field("height", want.height, out_ch.height);
        check_field("frame_end", 16'(want.frame_end), 16'(out_ch.frame_end));
      end
    end
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side in segments of varying pattern, with one long hold-off
  initial begin : det_receiver
    int mode;
    int seg_len;
    int step;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 80);
      for (step = 0; step < seg_len; step++) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= (step % 2 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Reset, directed table, then random phases
  initial begin : anchor_source
    int       i;
    int       phase;
    int       items_left;
    int       burst;
    logic [2:0] cur_preset;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.box_w <= '0;
    in_ch.box_h <= '0;
    in_ch.scores_0_3 <= '0;
    in_ch.scores_4_7 <= '0;
    in_ch.scores_8_11 <= '0;
    in_ch.scores_12_15 <= '0;
    in_ch.last_anchor <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table, switching presets only when idle
    cur_preset = 3'd0;
    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].preset != cur_preset) begin
        drain_pipe();
        cur_preset = DIR_TABLE[i].preset;
        apply_config(PRESETS[cur_preset]);
      end
      send_anchor(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      idle_gap($urandom_range(0, 2));
    end

    // Random anchors in bursts, new settings per phase
    for (phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      apply_config(rand_config(phase));
      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        burst = $urandom_range(1, 40);
        while (burst > 0 && items_left > 0) begin
          send_anchor(rand_anchor(), 1'b0, REJECT_ITEM);
          burst--;
          items_left--;
        end
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
    end

    drain_pipe();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
